// File: design/lpe_pkg.sv
// Shared types and constants for the line position estimator.
package lpe_pkg;

  localparam int Channels     = 8;
  localparam int PositionStep = 128;
  localparam int SampleBits   = 12;
  localparam int ChBits       = 3;
  localparam int LevelMax     = (1 << SampleBits) - 1;

  localparam logic [1:0] KIND_ON_LINE = 2'd0;
  localparam logic [1:0] KIND_LEFT    = 2'd1;
  localparam logic [1:0] KIND_RIGHT   = 2'd2;
  localparam logic [1:0] KIND_CENTRE  = 2'd3;

  localparam logic [2:0] REG_OFF_LO = 3'd0;
  localparam logic [2:0] REG_OFF_HI = 3'd1;
  localparam logic [2:0] REG_SPN_LO = 3'd2;
  localparam logic [2:0] REG_SPN_HI = 3'd3;
  localparam logic [2:0] REG_THRESH = 3'd4;
  localparam logic [2:0] REG_LIMIT  = 3'd5;

  typedef struct packed {
    logic [47:0] off_lo;
    logic [47:0] off_hi;
    logic [47:0] spn_lo;
    logic [47:0] spn_hi;
    logic [11:0] thresh;
    logic [9:0]  limit;
  } cfg_t;

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_NORM = 7'b0000010,
    ST_NDIV = 7'b0000100,
    ST_SCAN = 7'b0001000,
    ST_CENT = 7'b0010000,
    ST_CDIV = 7'b0100000,
    ST_DONE = 7'b1000000
  } state_e;

  typedef struct packed {
    logic             load;
    logic             norm_start;
    logic             norm_finish;
    logic [ChBits-1:0] ch;
    logic             scan;
    logic             cent_start;
    logic             cent_side;
    logic             cent_finish;
    logic             finish;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic seen;
  } sts_t;

  function automatic logic signed [12:0] weight(input logic [ChBits-1:0] i);
    int w;
    if (int'(i) < Channels / 2) w = (Channels / 2 - int'(i)) * PositionStep;
    else w = (Channels / 2 - int'(i) - 1) * PositionStep;
    return 13'(w);
  endfunction

endpackage

// File: design/lpe_div.sv
// Signed truncating radix-2 divider, one quotient bit per cycle.
module lpe_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [31:0] num_i,
  input  logic        [15:0] den_i,
  output logic               done_o,
  output logic signed [31:0] quot_o
);
  logic [31:0] rem_q, rem_d, quo_q, quo_d;
  logic [15:0] den_q;
  logic        neg_q, busy_q, busy_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [32:0] trial;
  logic [31:0] absn;

  assign absn  = num_i[31] ? 32'(-num_i) : num_i;
  assign trial = {rem_q, quo_q[31]} - {17'd0, den_q};

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    busy_d = busy_q;
    cnt_d  = cnt_q;
    if (start_i) begin
      rem_d = '0; quo_d = absn; busy_d = 1'b1; cnt_d = 6'd32;
    end else if (busy_q) begin
      if (!trial[32]) rem_d = trial[31:0];
      else rem_d = {rem_q[30:0], quo_q[31]};
      quo_d  = {quo_q[30:0], !trial[32]};
      cnt_d  = cnt_q - 6'd1;
      busy_d = (cnt_q != 6'd1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (start_i) begin
      den_q <= den_i;
      neg_q <= num_i[31];
    end
  end

  assign done_o = busy_q && (cnt_q == 6'd1);
  assign quot_o = neg_q ? 32'(-quo_d) : quo_d;
endmodule

// File: design/lpe_datapath.sv
// Normalisation, filtering, edge search and centroid datapath.
module lpe_datapath (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  lpe_pkg::cfg_t        cfg_i,
  input  logic [95:0]          raw_i,
  input  lpe_pkg::cmd_t        cmd_i,
  output lpe_pkg::sts_t        sts_o,
  output logic [46:0]          res_o
);
  logic [11:0] raw_q [lpe_pkg::Channels];
  logic [11:0] lvl_q [lpe_pkg::Channels];
  logic [2:0]  hi_q, lo_q;
  logic        seen_q;
  logic signed [10:0] hpos_q, lpos_q;
  logic [1:0]  kind_q;
  logic        div_start, div_done;
  logic signed [31:0] num, quot;
  logic [15:0] den;
  logic [11:0] off, spn;
  logic [95:0] offs, spns;
  logic signed [31:0] cacc;
  logic [15:0] csum;
  logic [2:0]  cc, cl, cr;
  logic signed [31:0] v;
  logic [11:0] vc;
  logic signed [10:0] cq;
  logic [10:0] mh, ml;
  logic        seen_c;
  logic [2:0]  hi_c, lo_c;

  assign offs = {cfg_i.off_hi, cfg_i.off_lo};
  assign spns = {cfg_i.spn_hi, cfg_i.spn_lo};
  assign off  = offs[12*cmd_i.ch +: 12];
  assign spn  = spns[12*cmd_i.ch +: 12];

  assign cc = cmd_i.cent_side ? lo_q : hi_q;
  assign cl = (cc == 3'd0) ? cc : cc - 3'd1;
  assign cr = (cc == 3'd7) ? cc : cc + 3'd1;

  always_comb begin
    cacc = 32'(lpe_pkg::weight(cc)) * $signed({1'b0, lvl_q[cc]}) * 2
         + 32'(lpe_pkg::weight(cl)) * $signed({1'b0, lvl_q[cl]})
         + 32'(lpe_pkg::weight(cr)) * $signed({1'b0, lvl_q[cr]})
         - 32'(lpe_pkg::weight(cc)) * $signed({1'b0, lvl_q[cc]});
    csum = 16'(lvl_q[cc]) + 16'(lvl_q[cl]) + 16'(lvl_q[cr]);
  end

  assign div_start = cmd_i.norm_start || cmd_i.cent_start;
  assign num = cmd_i.norm_start
             ? (32'($signed({1'b0, raw_q[cmd_i.ch]})) - 32'($signed({1'b0, off}))) * 1000
             : cacc;
  assign den = cmd_i.norm_start ? 16'(spn) : csum;

  lpe_div u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(num), .den_i(den),
    .done_o(div_done), .quot_o(quot)
  );

  always_comb begin
    v = 32'sd1000 - quot;
    if (spn == 12'd0 || v < 0) vc = '0;
    else if (v > lpe_pkg::LevelMax) vc = 12'(lpe_pkg::LevelMax);
    else vc = v[11:0];
    if (quot > 1023) cq = 11'sd1023;
    else if (quot < -1024) cq = -11'sd1024;
    else cq = quot[10:0];
  end

  always_comb begin
    seen_c = 1'b0;
    hi_c   = '0;
    lo_c   = '0;
    for (int i = 0; i < lpe_pkg::Channels; i++)
      if (lvl_q[i] > cfg_i.thresh) begin seen_c = 1'b1; hi_c = 3'(i); end
    for (int i = lpe_pkg::Channels - 1; i >= 0; i--)
      if (lvl_q[i] > cfg_i.thresh) lo_c = 3'(i);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      for (int i = 0; i < lpe_pkg::Channels; i++) raw_q[i] <= raw_i[12*i +: 12];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < lpe_pkg::Channels; i++) lvl_q[i] <= '0;
      hpos_q <= '0; lpos_q <= '0; seen_q <= 1'b0; kind_q <= '0;
      hi_q <= '0; lo_q <= '0;
    end else begin
      if (cmd_i.norm_finish)
        lvl_q[cmd_i.ch] <= 12'((14'(lvl_q[cmd_i.ch]) * 3 + 14'(vc)) >> 2);
      if (cmd_i.scan) begin
        seen_q <= seen_c;
        hi_q   <= hi_c;
        lo_q   <= lo_c;
      end
      if (cmd_i.cent_finish) begin
        if (cmd_i.cent_side) lpos_q <= cq;
        else hpos_q <= cq;
      end
      if (cmd_i.finish) begin
        if (seen_q) kind_q <= lpe_pkg::KIND_ON_LINE;
        else if (hpos_q < -$signed({1'b0, cfg_i.limit})) kind_q <= lpe_pkg::KIND_LEFT;
        else if (hpos_q > $signed({1'b0, cfg_i.limit})) kind_q <= lpe_pkg::KIND_RIGHT;
        else kind_q <= lpe_pkg::KIND_CENTRE;
      end
    end
  end

  assign mh = hpos_q[10] ? 11'(-hpos_q) : hpos_q;
  assign ml = lpos_q[10] ? 11'(-lpos_q) : lpos_q;
  assign sts_o.div_done = div_done;
  assign sts_o.seen = seen_q;
  assign res_o = {seen_q, kind_q,
                  (mh < ml) ? lpos_q : hpos_q,
                  (mh < ml) ? hpos_q : lpos_q,
                  lpos_q, hpos_q};
endmodule

// File: design/lpe_ctrl.sv
// Sequencing state machine for one frame.
module lpe_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_fire_i,
  input  logic          out_free_i,
  input  lpe_pkg::sts_t sts_i,
  output lpe_pkg::cmd_t cmd_o,
  output logic          busy_o,
  output logic          out_load_o
);
  lpe_pkg::state_e st_q, st_d;
  logic [2:0] ch_q, ch_d;
  logic       side_q, side_d;

  always_comb begin
    st_d = st_q; ch_d = ch_q; side_d = side_q;
    cmd_o = '0;
    cmd_o.ch = ch_q;
    cmd_o.cent_side = side_q;
    out_load_o = 1'b0;
    unique case (st_q)
      lpe_pkg::ST_IDLE: if (in_fire_i) begin
        cmd_o.load = 1'b1; ch_d = '0; st_d = lpe_pkg::ST_NORM;
      end
      lpe_pkg::ST_NORM: begin
        cmd_o.norm_start = 1'b1; st_d = lpe_pkg::ST_NDIV;
      end
      lpe_pkg::ST_NDIV: if (sts_i.div_done) begin
        cmd_o.norm_finish = 1'b1;
        ch_d = ch_q + 3'd1;
        st_d = (ch_q == 3'd7) ? lpe_pkg::ST_SCAN : lpe_pkg::ST_NORM;
      end
      lpe_pkg::ST_SCAN: begin
        cmd_o.scan = 1'b1; side_d = 1'b0; st_d = lpe_pkg::ST_CENT;
      end
      lpe_pkg::ST_CENT: begin
        if (sts_i.seen) begin
          cmd_o.cent_start = 1'b1; st_d = lpe_pkg::ST_CDIV;
        end else begin
          st_d = lpe_pkg::ST_DONE;
        end
      end
      lpe_pkg::ST_CDIV: if (sts_i.div_done) begin
        cmd_o.cent_finish = 1'b1;
        side_d = !side_q;
        st_d = side_q ? lpe_pkg::ST_DONE : lpe_pkg::ST_CENT;
      end
      lpe_pkg::ST_DONE: begin
        if (!side_q) begin
          cmd_o.finish = 1'b1; side_d = 1'b1;
        end else if (out_free_i) begin
          out_load_o = 1'b1; side_d = 1'b0; st_d = lpe_pkg::ST_IDLE;
        end
      end
      default: st_d = lpe_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= lpe_pkg::ST_IDLE; ch_q <= '0; side_q <= 1'b0;
    end else begin
      st_q <= st_d; ch_q <= ch_d; side_q <= side_d;
    end
  end

  assign busy_o = (st_q != lpe_pkg::ST_IDLE);

`ifndef SYNTHESIS
  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |-> st_q == lpe_pkg::ST_IDLE) else $error("load outside idle");
  a_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(st_q)) else $error("state not one-hot");
  a_scan_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.scan |=> st_q == lpe_pkg::ST_CENT) else $error("scan sequence");
`endif
endmodule

// File: design/line_position_estimator.sv
// Top level of the line position estimator.
// Frames are handled one at a time on one shared divider: eight normalising
// divisions, then a centroid division for each side when the line is seen. The
// result waits in an output register, and the input is ready again in the same cycle
// as the result becomes valid. A frame whose result finds that register still full
// holds there, and the input stays stalled until the register is free.
module line_position_estimator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [95:0] s_axis_tdata,  // raw_ch0 .. raw_ch7
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,  // high, low, nearest, farthest
  output logic [2:0]  m_axis_tuser   // lost_kind, line_seen
);
  lpe_pkg::cfg_t cfg_q;
  lpe_pkg::cmd_t cmd;
  lpe_pkg::sts_t sts;
  logic busy, out_load, ov_q;
  logic [46:0] res, od_q;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign idx = paddr[5:3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.off_lo <= '0; cfg_q.off_hi <= '0;
      cfg_q.spn_lo <= '1; cfg_q.spn_hi <= '1;
      cfg_q.thresh <= 12'd500; cfg_q.limit <= 10'd410;
    end else if (psel && penable && pwrite) begin
      unique case (idx)
        lpe_pkg::REG_OFF_LO: cfg_q.off_lo <= pwdata[47:0];
        lpe_pkg::REG_OFF_HI: cfg_q.off_hi <= pwdata[47:0];
        lpe_pkg::REG_SPN_LO: cfg_q.spn_lo <= pwdata[47:0];
        lpe_pkg::REG_SPN_HI: cfg_q.spn_hi <= pwdata[47:0];
        lpe_pkg::REG_THRESH: cfg_q.thresh <= pwdata[11:0];
        lpe_pkg::REG_LIMIT:  cfg_q.limit  <= pwdata[9:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      lpe_pkg::REG_OFF_LO: prdata = 64'(cfg_q.off_lo);
      lpe_pkg::REG_OFF_HI: prdata = 64'(cfg_q.off_hi);
      lpe_pkg::REG_SPN_LO: prdata = 64'(cfg_q.spn_lo);
      lpe_pkg::REG_SPN_HI: prdata = 64'(cfg_q.spn_hi);
      lpe_pkg::REG_THRESH: prdata = 64'(cfg_q.thresh);
      lpe_pkg::REG_LIMIT:  prdata = 64'(cfg_q.limit);
      default: prdata = '0;
    endcase
  end

  assign s_axis_tready = !busy;

  lpe_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_fire_i(s_axis_tvalid && s_axis_tready),
    .out_free_i(!ov_q || m_axis_tready), .sts_i(sts), .cmd_o(cmd),
    .busy_o(busy), .out_load_o(out_load)
  );

  lpe_datapath u_dp (
    .clk_i, .rst_ni, .cfg_i(cfg_q), .raw_i(s_axis_tdata), .cmd_i(cmd),
    .sts_o(sts), .res_o(res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ov_q <= 1'b0;
    else if (out_load) ov_q <= 1'b1;
    else if (m_axis_tready) ov_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (out_load) od_q <= res;
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = {4'd0, od_q[43:0]};
  assign m_axis_tuser  = od_q[46:44];
endmodule
